### sv/ypc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ypc_pkg
// Shared constants, codes and helpers of the yaw/pitch camera block.
// ----------------------------------------------------------------------------
package ypc_pkg;

  // operation codes
  localparam logic OP_LOOK = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_LOOK_SENS = 2'd0;
  localparam logic [1:0] CFG_MOVE_SPEED = 2'd1;
  localparam logic [1:0] CFG_CURSOR_X = 2'd2;
  localparam logic [1:0] CFG_CURSOR_Y = 2'd3;

  // register reset values
  localparam logic [15:0] LOOK_SENS_RESET = 16'd6554;
  localparam logic [15:0] MOVE_SPEED_RESET = 16'd2560;
  localparam logic [19:0] CURSOR_X_RESET = 20'd10240;
  localparam logic [19:0] CURSOR_Y_RESET = 20'd5760;

  // angles in Q16 degrees
  localparam logic signed [35:0] HALF_TURN = 36'sd11796480;
  localparam logic signed [35:0] FULL_TURN = 36'sd23592960;
  localparam logic signed [35:0] TURN_HI = 36'sd24159191040;
  localparam logic signed [35:0] PITCH_MAX = 36'sd5832704;
  localparam logic signed [25:0] ANG_QUARTER = 26'sd5898240;
  localparam logic signed [25:0] ANG_HALF = 26'sd11796480;
  localparam logic signed [24:0] YAW_RESET = -25'sd5898240;
  localparam logic [3:0] WRAP_TOP = 4'd10;

  // cordic start gain, Q2.30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // state reset values
  localparam logic signed [15:0] DIR_Z_RESET = -16'sd32767;
  localparam logic signed [31:0] POS_Z_RESET = 32'sd196608;

  // arctangent of 2^-i in Q16 degrees
  function automatic logic [22:0] atan_q16(input logic [4:0] i);
    logic [22:0] r;
    unique case (i)
      5'd0: r = 23'd2949120;
      5'd1: r = 23'd1740967;
      5'd2: r = 23'd919879;
      5'd3: r = 23'd466945;
      5'd4: r = 23'd234379;
      5'd5: r = 23'd117304;
      5'd6: r = 23'd58666;
      5'd7: r = 23'd29335;
      5'd8: r = 23'd14668;
      5'd9: r = 23'd7334;
      5'd10: r = 23'd3667;
      5'd11: r = 23'd1833;
      5'd12: r = 23'd917;
      5'd13: r = 23'd458;
      5'd14: r = 23'd229;
      5'd15: r = 23'd115;
      5'd16: r = 23'd57;
      5'd17: r = 23'd29;
      5'd18: r = 23'd14;
      5'd19: r = 23'd7;
      5'd20: r = 23'd4;
      5'd21: r = 23'd2;
      5'd22: r = 23'd1;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

  // saturate to 16 bits signed
  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd32767) r = 16'sh7fff;
    else if (v < -36'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // saturate to 32 bits signed
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7fffffff;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/ypc_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ypc_cordic
// Iterative rotation-mode cordic, one micro-rotation per cycle, giving the
// cosine and sine of a Q16 degree angle in Q1.15.
// ----------------------------------------------------------------------------
module ypc_cordic import ypc_pkg::*; #(
  parameter int STEPS = 16
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire logic signed [24:0]  angle,
  output logic                     done,
  output logic signed [15:0]       cos_q,
  output logic signed [15:0]       sin_q
);

  localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [IW-1:0] LAST = IW'(STEPS - 1);

  logic              busy_r, done_r, flip_r;
  logic [IW-1:0]     idx_r;
  logic signed [33:0] x_r, y_r;
  logic signed [25:0] z_r;
  logic signed [15:0] cos_r, sin_r;

  logic signed [25:0] ang_ext, z_start;
  logic               flip_start;
  logic signed [33:0] xs, ys, x_nxt, y_nxt, xr, yr;
  logic signed [25:0] at, z_nxt;

  // fold the angle into the right half plane
  always_comb begin
    ang_ext = 26'(angle);
    z_start = ang_ext;
    flip_start = 1'b0;
    if (ang_ext > ANG_QUARTER) begin
      z_start = ang_ext - ANG_HALF;
      flip_start = 1'b1;
    end else if (ang_ext < -ANG_QUARTER) begin
      z_start = ang_ext + ANG_HALF;
      flip_start = 1'b1;
    end
  end

  // one micro-rotation
  always_comb begin
    xs = x_r >>> idx_r;
    ys = y_r >>> idx_r;
    at = $signed({3'b000, atan_q16(5'(idx_r))});
    if (z_r >= 26'sd0) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
    xr = (x_nxt + 34'sd16384) >>> 15;
    yr = (y_nxt + 34'sd16384) >>> 15;
    if (flip_r) begin
      xr = -xr;
      yr = -yr;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r <= '0;
        flip_r <= flip_start;
        x_r <= CORDIC_GAIN;
        y_r <= '0;
        z_r <= z_start;
      end else if (busy_r) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
        idx_r <= idx_r + 1'b1;
        if (idx_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          cos_r <= sat16(36'(xr));
          sin_r <= sat16(36'(yr));
        end
      end
    end
  end

  assign done = done_r;
  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule
`default_nettype wire

### sv/yaw_pitch_camera_orientation_move.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yaw_pitch_camera_orientation_move
// First-person camera: yaw/pitch from cursor motion, view direction by
// cordic, position moves along the view or right vector with saturation.
// ----------------------------------------------------------------------------
// One transaction at a time. A look transaction takes two passes of the
// shared cordic plus a shift-subtract yaw wrap; a move transaction takes
// one cordic pass and ten position updates through the shared multiplier.
// The result sits in an output register, so the next transaction can start
// while it waits.
module yaw_pitch_camera_orientation_move import ypc_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [19:0]         cfg_wdata,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire                      in_operation,
  input  wire logic [19:0]         in_cursor_x,
  input  wire logic [19:0]         in_cursor_y,
  input  wire                      in_key_forward,
  input  wire                      in_key_left,
  input  wire                      in_key_back,
  input  wire                      in_key_right,
  input  wire logic [15:0]         in_frame_time,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [15:0]       out_dir_x,
  output logic signed [15:0]       out_dir_y,
  output logic signed [15:0]       out_dir_z,
  output logic signed [31:0]       out_pos_x,
  output logic signed [31:0]       out_pos_y,
  output logic signed [31:0]       out_pos_z
);

  typedef enum logic [3:0] {
    S_IDLE, S_LK_MULX, S_LK_YAW, S_LK_WRAP, S_CY_GO, S_CY_WAIT, S_CP_GO,
    S_CP_WAIT, S_LK_DX, S_LK_DZ, S_LK_FIN, S_MV_MUL, S_MV_STEP, S_MV_APPLY,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               en;
    logic [1:0]         axis;
    logic               plus;
    logic signed [16:0] comp;
  } apply_t;

  state_t state_r;

  // configuration and camera state
  logic [15:0]        sens_r, speed_r;
  logic [19:0]        prev_x_r, prev_y_r;
  logic signed [24:0] yaw_r;
  logic signed [23:0] pitch_r;
  logic signed [15:0] dir_r [3];
  logic signed [31:0] pos_r [3];

  // transaction latch
  logic               op_r, kf_r, kl_r, kb_r, kr_r;
  logic [19:0]        cx_r, cy_r;
  logic [15:0]        ft_r;

  // working registers
  logic signed [47:0] mul_r;
  logic signed [35:0] t_r;
  logic [3:0]         k_r;
  logic [3:0]         a_r;
  logic [24:0]        step_r;
  logic signed [15:0] cyw_r, syw_r, cp_r, sp_r;
  logic               en_r, plus_r;
  logic [1:0]         ax_r;

  // output register
  logic               out_valid_r;
  logic signed [15:0] out_dx_r, out_dy_r, out_dz_r;
  logic signed [31:0] out_px_r, out_py_r, out_pz_r;

  // shared cordic
  logic               cord_start, cord_done;
  logic signed [24:0] cord_ang;
  logic signed [15:0] cord_cos, cord_sin;

  assign cord_start = (state_r == S_CY_GO) || (state_r == S_CP_GO);
  assign cord_ang = (state_r == S_CP_GO) ? 25'(pitch_r) : yaw_r;

  ypc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .angle (cord_ang),
    .done  (cord_done),
    .cos_q (cord_cos),
    .sin_q (cord_sin)
  );

  // cursor differences
  logic signed [21:0] dx, dy;
  assign dx = $signed({2'b00, cx_r}) - $signed({2'b00, prev_x_r});
  assign dy = $signed({2'b00, prev_y_r}) - $signed({2'b00, cy_r});

  // position update schedule for a move transaction
  apply_t ap;
  always_comb begin
    ap = '0;
    unique case (a_r)
      4'd0, 4'd1, 4'd2: begin
        ap.en = kf_r;
        ap.axis = a_r[1:0];
        ap.plus = 1'b1;
        ap.comp = 17'(dir_r[a_r[1:0]]);
      end
      4'd3, 4'd4, 4'd5: begin
        ap.en = kb_r;
        ap.axis = 2'(a_r - 4'd3);
        ap.plus = 1'b0;
        ap.comp = 17'(dir_r[2'(a_r - 4'd3)]);
      end
      4'd6: begin
        ap.en = kl_r;
        ap.axis = 2'd0;
        ap.comp = -17'(syw_r);
      end
      4'd7: begin
        ap.en = kl_r;
        ap.axis = 2'd2;
        ap.comp = 17'(cyw_r);
      end
      4'd8: begin
        ap.en = kr_r;
        ap.axis = 2'd0;
        ap.plus = 1'b1;
        ap.comp = -17'(syw_r);
      end
      4'd9: begin
        ap.en = kr_r;
        ap.axis = 2'd2;
        ap.plus = 1'b1;
        ap.comp = 17'(cyw_r);
      end
      default: ap = '0;
    endcase
  end

  // shared multiplier operand select
  logic signed [25:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [47:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_LK_MULX: begin
        mul_a = $signed({10'd0, sens_r});
        mul_b = dx;
      end
      S_LK_YAW: begin
        mul_a = $signed({10'd0, sens_r});
        mul_b = dy;
      end
      S_LK_DX: begin
        mul_a = 26'(cyw_r);
        mul_b = 22'(cp_r);
      end
      S_LK_DZ: begin
        mul_a = 26'(syw_r);
        mul_b = 22'(cp_r);
      end
      S_MV_MUL: begin
        mul_a = $signed({10'd0, speed_r});
        mul_b = $signed({6'd0, ft_r});
      end
      S_MV_APPLY: begin
        mul_a = $signed({1'b0, step_r});
        mul_b = 22'(ap.comp);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // yaw, wrap, pitch and position arithmetic
  logic signed [35:0] d4, t_start, cand, t_nxt, p_sum, p_clamp, d15, pos_sum;
  logic signed [47:0] r4, r8, r15;
  always_comb begin
    r4 = (mul_r + 48'sd8) >>> 4;
    r8 = (mul_r + 48'sd128) >>> 8;
    r15 = (mul_r + 48'sd16384) >>> 15;
    d4 = r4[35:0];
    d15 = r15[35:0];
    t_start = 36'(yaw_r) + d4 + HALF_TURN;
    if (t_start < 36'sd0) t_start = t_start + TURN_HI;
    cand = FULL_TURN <<< k_r;
    t_nxt = (t_r >= cand) ? (t_r - cand) : t_r;
    p_sum = 36'(pitch_r) + d4;
    if (p_sum > PITCH_MAX) p_clamp = PITCH_MAX;
    else if (p_sum < -PITCH_MAX) p_clamp = -PITCH_MAX;
    else p_clamp = p_sum;
    pos_sum = plus_r ? (36'(pos_r[ax_r]) + d15) : (36'(pos_r[ax_r]) - d15);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sens_r <= LOOK_SENS_RESET;
      speed_r <= MOVE_SPEED_RESET;
      prev_x_r <= CURSOR_X_RESET;
      prev_y_r <= CURSOR_Y_RESET;
      yaw_r <= YAW_RESET;
      pitch_r <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= DIR_Z_RESET;
      pos_r[0] <= '0;
      pos_r[1] <= '0;
      pos_r[2] <= POS_Z_RESET;
      out_valid_r <= 1'b0;
    end else begin
      mul_r <= prod;
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= in_operation;
            cx_r <= in_cursor_x;
            cy_r <= in_cursor_y;
            kf_r <= in_key_forward;
            kl_r <= in_key_left;
            kb_r <= in_key_back;
            kr_r <= in_key_right;
            ft_r <= in_frame_time;
            state_r <= (in_operation == OP_MOVE) ? S_MV_MUL : S_LK_MULX;
          end
        end
        S_LK_MULX: begin
          prev_x_r <= cx_r;
          state_r <= S_LK_YAW;
        end
        S_LK_YAW: begin
          prev_y_r <= cy_r;
          t_r <= t_start;
          k_r <= WRAP_TOP;
          state_r <= S_LK_WRAP;
        end
        S_LK_WRAP: begin
          // first wrap cycle sees the pitch product
          if (k_r == WRAP_TOP) pitch_r <= p_clamp[23:0];
          t_r <= t_nxt;
          k_r <= k_r - 1'b1;
          if (k_r == 4'd0) begin
            yaw_r <= 25'(t_nxt - HALF_TURN);
            state_r <= S_CY_GO;
          end
        end
        S_CY_GO: state_r <= S_CY_WAIT;
        S_CY_WAIT: begin
          if (cord_done) begin
            cyw_r <= cord_cos;
            syw_r <= cord_sin;
            a_r <= '0;
            state_r <= (op_r == OP_MOVE) ? S_MV_APPLY : S_CP_GO;
          end
        end
        S_CP_GO: state_r <= S_CP_WAIT;
        S_CP_WAIT: begin
          if (cord_done) begin
            cp_r <= cord_cos;
            sp_r <= cord_sin;
            state_r <= S_LK_DX;
          end
        end
        S_LK_DX: state_r <= S_LK_DZ;
        S_LK_DZ: begin
          dir_r[0] <= sat16(d15);
          state_r <= S_LK_FIN;
        end
        S_LK_FIN: begin
          dir_r[2] <= sat16(d15);
          dir_r[1] <= sp_r;
          state_r <= S_DONE;
        end
        S_MV_MUL: state_r <= S_MV_STEP;
        S_MV_STEP: begin
          step_r <= r8[24:0];
          state_r <= S_CY_GO;
        end
        S_MV_APPLY: begin
          // product for entry a_r, update for the entry before it
          en_r <= ap.en;
          ax_r <= ap.axis;
          plus_r <= ap.plus;
          if (a_r != 4'd0 && en_r) pos_r[ax_r] <= sat32(pos_sum);
          a_r <= a_r + 1'b1;
          if (a_r == 4'd10) state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_dx_r <= dir_r[0];
            out_dy_r <= dir_r[1];
            out_dz_r <= dir_r[2];
            out_px_r <= pos_r[0];
            out_py_r <= pos_r[1];
            out_pz_r <= pos_r[2];
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOOK_SENS: if (cfg_wdata[15:0] != 16'd0) sens_r <= cfg_wdata[15:0];
          CFG_MOVE_SPEED: if (cfg_wdata[15:0] != 16'd0) speed_r <= cfg_wdata[15:0];
          CFG_CURSOR_X: prev_x_r <= cfg_wdata;
          CFG_CURSOR_Y: prev_y_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_dir_x = out_dx_r;
  assign out_dir_y = out_dy_r;
  assign out_dir_z = out_dz_r;
  assign out_pos_x = out_px_r;
  assign out_pos_y = out_py_r;
  assign out_pos_z = out_pz_r;

  // pitch stays inside its clamp
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (36'(pitch_r) <= PITCH_MAX) && (36'(pitch_r) >= -PITCH_MAX))
    else $error("pitch out of range");

  // yaw stays inside one turn
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    (36'(yaw_r) < HALF_TURN) && (36'(yaw_r) >= -HALF_TURN))
    else $error("yaw out of range");

  // cordic finishes only while the sequencer waits for it
  a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
    cord_done |-> (state_r == S_CY_WAIT) || (state_r == S_CP_WAIT))
    else $error("cordic done outside a wait state");

  // a cordic start leads straight to its wait state
  a_cordic_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cord_start |=> (state_r == S_CY_WAIT) || (state_r == S_CP_WAIT))
    else $error("cordic start not followed by wait");

endmodule
`default_nettype wire

### tb/yaw_pitch_camera_orientation_move_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaw_pitch_camera_orientation_move_tb
// Drives look and move transactions with random bursts and output stalls,
// predicts direction and position in fixed point and compares every result.
// ----------------------------------------------------------------------------
module yaw_pitch_camera_orientation_move_tb;
  import ypc_pkg::*;

  localparam int STEPS = 16;

  typedef struct packed {
    logic        op;
    logic [19:0] cx;
    logic [19:0] cy;
    logic        kf;
    logic        kl;
    logic        kb;
    logic        kr;
    logic [15:0] ft;
  } cam_cmd_t;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } cam_view_t;

  typedef struct {
    cam_cmd_t  cmd;
    bit        typed;
    cam_view_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [19:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = 1'b0;
  logic [19:0] in_cursor_x = '0;
  logic [19:0] in_cursor_y = '0;
  logic in_key_forward = 1'b0;
  logic in_key_left = 1'b0;
  logic in_key_back = 1'b0;
  logic in_key_right = 1'b0;
  logic [15:0] in_frame_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_dir_x, out_dir_y, out_dir_z;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;

  yaw_pitch_camera_orientation_move #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_cursor_x(in_cursor_x), .in_cursor_y(in_cursor_y),
    .in_key_forward(in_key_forward), .in_key_left(in_key_left),
    .in_key_back(in_key_back), .in_key_right(in_key_right),
    .in_frame_time(in_frame_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_dir_x(out_dir_x), .out_dir_y(out_dir_y), .out_dir_z(out_dir_z),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // camera shadow state
  longint sens, speed, prev_x, prev_y, yaw, pitch;
  longint dirv[3];
  longint posv[3];

  cam_view_t views_due[$];
  int errors = 0;
  bit long_hold = 1'b0;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip16(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic longint clip32(longint v);
    return v > 64'sd2147483647 ? 64'sd2147483647 :
           (v < -64'sd2147483648 ? -64'sd2147483648 : v);
  endfunction

  // rotation-mode cordic on a folded angle
  task automatic cordic_sincos(input longint ang, output longint c, output longint s);
    longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1, 0};
    longint x, y, z, xs, ys;
    bit flip;
    x = 652032874;
    y = 0;
    flip = 0;
    if (ang > 90 * 65536) begin
      ang -= 180 * 65536; flip = 1;
    end else if (ang < -90 * 65536) begin
      ang += 180 * 65536; flip = 1;
    end
    z = ang;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= tbl[i];
      end else begin
        x += ys; y -= xs; z += tbl[i];
      end
    end
    x = rshr(x, 15);
    y = rshr(y, 15);
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip16(x);
    s = clip16(y);
  endtask

  task automatic shadow_reset();
    sens = LOOK_SENS_RESET; speed = MOVE_SPEED_RESET;
    prev_x = CURSOR_X_RESET; prev_y = CURSOR_Y_RESET;
    yaw = -90 * 65536; pitch = 0;
    dirv = '{0, 0, -32767};
    posv = '{0, 0, 196608};
  endtask

  task automatic shadow_cfg(input logic [1:0] idx, input logic [19:0] val);
    case (idx)
      CFG_LOOK_SENS: if (val[15:0] != 0) sens = val[15:0];
      CFG_MOVE_SPEED: if (val[15:0] != 0) speed = val[15:0];
      CFG_CURSOR_X: prev_x = val;
      CFG_CURSOR_Y: prev_y = val;
    endcase
  endtask

  task automatic nudge_pos(input int axis, input longint comp, input longint stp,
                           input bit add);
    longint d;
    d = rshr(comp * stp, 15);
    posv[axis] = clip32(add ? posv[axis] + d : posv[axis] - d);
  endtask

  // advance the shadow camera by one transaction
  task automatic camera_step(input cam_cmd_t c, output cam_view_t v);
    longint dx, dy, t, cyw, syw, cp, sp, stp;
    if (c.op == OP_LOOK) begin
      dx = longint'(c.cx) - prev_x;
      dy = prev_y - longint'(c.cy);
      prev_x = c.cx;
      prev_y = c.cy;
      t = yaw + rshr(dx * sens, 4) + 180 * 65536;
      t = t % (360 * 65536);
      if (t < 0) t += 360 * 65536;
      yaw = t - 180 * 65536;
      pitch += rshr(dy * sens, 4);
      if (pitch > 89 * 65536) pitch = 89 * 65536;
      if (pitch < -89 * 65536) pitch = -89 * 65536;
      cordic_sincos(yaw, cyw, syw);
      cordic_sincos(pitch, cp, sp);
      dirv[0] = clip16(rshr(cyw * cp, 15));
      dirv[1] = sp;
      dirv[2] = clip16(rshr(syw * cp, 15));
    end else begin
      stp = rshr(speed * longint'(c.ft), 8);
      cordic_sincos(yaw, cyw, syw);
      if (c.kf) for (int k = 0; k < 3; k++) nudge_pos(k, dirv[k], stp, 1);
      if (c.kb) for (int k = 0; k < 3; k++) nudge_pos(k, dirv[k], stp, 0);
      if (c.kl) begin
        nudge_pos(0, -syw, stp, 0); nudge_pos(2, cyw, stp, 0);
      end
      if (c.kr) begin
        nudge_pos(0, -syw, stp, 1); nudge_pos(2, cyw, stp, 1);
      end
    end
    v.dx = dirv[0]; v.dy = dirv[1]; v.dz = dirv[2];
    v.px = posv[0]; v.py = posv[1]; v.pz = posv[2];
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // result checking
  always @(posedge clk) begin
    cam_view_t w;
    if (rst_n && out_valid && out_ready) begin
      if (views_due.size() == 0) begin
        $display("unexpected result at %0t", $time);
        errors++;
      end else begin
        w = views_due.pop_front();
        if (out_dir_x !== w.dx) report("dir_x", out_dir_x, w.dx);
        if (out_dir_y !== w.dy) report("dir_y", out_dir_y, w.dy);
        if (out_dir_z !== w.dz) report("dir_z", out_dir_z, w.dz);
        if (out_pos_x !== w.px) report("pos_x", out_pos_x, w.px);
        if (out_pos_y !== w.py) report("pos_y", out_pos_y, w.py);
        if (out_pos_z !== w.pz) report("pos_z", out_pos_z, w.pz);
      end
    end
  end

  // receiver stall pattern, with one long hold-off when asked
  always @(posedge clk) begin
    int cnt;
    if (long_hold) begin
      out_ready <= 1'b0;
      cnt++;
      if (cnt > 400) long_hold <= 1'b0;
    end else begin
      cnt = 0;
      case ($urandom_range(0, 3))
        0: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cfg(idx, val);
    @(posedge clk);
  endtask

  // one transaction; the prediction is taken when it is accepted
  int burst_left = 0;
  task automatic send(input cam_cmd_t c, input bit typed, input cam_view_t want);
    cam_view_t v;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_operation <= c.op; in_cursor_x <= c.cx; in_cursor_y <= c.cy;
    in_key_forward <= c.kf; in_key_left <= c.kl; in_key_back <= c.kb;
    in_key_right <= c.kr; in_frame_time <= c.ft;
    do @(posedge clk); while (!in_ready);
    camera_step(c, v);
    if (typed && v != want)
      $display("note: typed row differs from prediction at %0t", $time);
    views_due.push_back(typed ? want : v);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (views_due.size() != 0 && guard < 200000) begin
      @(posedge clk); guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  function automatic cam_cmd_t mk(logic op, logic [19:0] x, logic [19:0] y,
                                  logic [3:0] keys, logic [15:0] ft);
    cam_cmd_t c;
    c.op = op; c.cx = x; c.cy = y;
    {c.kf, c.kl, c.kb, c.kr} = keys; c.ft = ft;
    return c;
  endfunction

  function automatic cam_cmd_t rand_cmd();
    cam_cmd_t c;
    c = '0;
    c.op = 1'($urandom_range(0, 1));
    c.cx = 20'(prev_x + $urandom_range(0, 4000) - 2000);
    c.cy = 20'(prev_y + $urandom_range(0, 4000) - 2000);
    if ($urandom_range(0, 7) == 0) begin
      c.cx = 20'($urandom); c.cy = 20'($urandom);
    end
    {c.kf, c.kl, c.kb, c.kr} = 4'($urandom_range(0, 15));
    c.ft = 16'($urandom);
    if ($urandom_range(0, 3) != 0) c.ft = 16'($urandom_range(0, 2000));
    return c;
  endfunction

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    cam_view_t nothing;
    nothing = '0;
    shadow_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; first row is read off the reset state
    r.typed = 1; r.cmd = mk(OP_MOVE, 20'd0, 20'd0, 4'b0000, 16'd0);
    r.want = '{16'sd0, 16'sd0, -16'sd32767, 32'sd0, 32'sd0, 32'sd196608};
    rows.push_back(r);
    r.typed = 0; r.want = nothing;
    rows.push_back('{mk(OP_LOOK, 20'd10240, 20'd5760, 4'b1111, 16'hffff), 0, nothing});
    rows.push_back('{mk(OP_MOVE, 20'hfffff, 20'hfffff, 4'b1000, 16'hffff), 0, nothing});
    rows.push_back('{mk(OP_MOVE, 20'd0, 20'd0, 4'b0010, 16'hffff), 0, nothing});
    rows.push_back('{mk(OP_MOVE, 20'd0, 20'd0, 4'b0100, 16'd30000), 0, nothing});
    rows.push_back('{mk(OP_MOVE, 20'd0, 20'd0, 4'b0001, 16'd30000), 0, nothing});
    rows.push_back('{mk(OP_MOVE, 20'd0, 20'd0, 4'b1010, 16'd30000), 0, nothing});
    rows.push_back('{mk(OP_LOOK, 20'hfffff, 20'd0, 4'b0, 16'd0), 0, nothing});
    rows.push_back('{mk(OP_LOOK, 20'd0, 20'hfffff, 4'b0, 16'd0), 0, nothing});
    rows.push_back('{mk(OP_LOOK, 20'd1200, 20'd5000, 4'b0, 16'd0), 0, nothing});
    rows.push_back('{mk(OP_LOOK, 20'd2200, 20'd6000, 4'b0, 16'd0), 0, nothing});
    rows.push_back('{mk(OP_LOOK, 20'd100, 20'd6000, 4'b0, 16'd0), 0, nothing});
    rows.push_back('{mk(OP_MOVE, 20'd0, 20'd0, 4'b1100, 16'd1000), 0, nothing});
    foreach (rows[i]) send(rows[i].cmd, rows[i].typed, rows[i].want);
    drain();

    // extreme speed, pitch pinned up, to drive positions into saturation
    write_reg(CFG_MOVE_SPEED, 20'hfffff);
    write_reg(CFG_MOVE_SPEED, 20'd0);
    write_reg(CFG_LOOK_SENS, 20'd0);
    write_reg(CFG_LOOK_SENS, 20'hffff);
    write_reg(CFG_CURSOR_X, 20'd0);
    write_reg(CFG_CURSOR_Y, 20'hfffff);
    send(mk(OP_LOOK, 20'd0, 20'd0, 4'b0000, 16'd0), 0, nothing);
    repeat (140) send(mk(OP_MOVE, 20'd0, 20'd0, 4'b1000, 16'hffff), 0, nothing);
    repeat (270) send(mk(OP_MOVE, 20'd0, 20'd0, 4'b0010, 16'hffff), 0, nothing);
    send(mk(OP_MOVE, 20'd0, 20'd0, 4'b1010, 16'hffff), 0, nothing);
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_LOOK_SENS, 20'd1); write_reg(CFG_MOVE_SPEED, 20'd1);
          write_reg(CFG_CURSOR_X, 20'd0); write_reg(CFG_CURSOR_Y, 20'hfffff);
        end
        1: begin
          write_reg(CFG_LOOK_SENS, 20'd6554); write_reg(CFG_MOVE_SPEED, 20'd2560);
          write_reg(CFG_CURSOR_X, 20'hfffff); write_reg(CFG_CURSOR_Y, 20'd0);
        end
        2: begin
          write_reg(CFG_LOOK_SENS, 20'($urandom_range(1, 65535)));
          write_reg(CFG_MOVE_SPEED, 20'($urandom_range(1, 65535)));
          write_reg(CFG_CURSOR_X, 20'($urandom));
          write_reg(CFG_CURSOR_Y, 20'($urandom));
        end
        default: begin
          write_reg(CFG_LOOK_SENS, 20'hffff); write_reg(CFG_MOVE_SPEED, 20'hffff);
        end
      endcase
      if (ph == 1) long_hold <= 1'b1;
      repeat (120) send(rand_cmd(), 0, nothing);
      drain();
    end

    if (errors == 0 && views_due.size() == 0) begin
      $display("yaw_pitch_camera_orientation_move test passed");
    end else begin
      if (views_due.size() != 0) $display("%0d results missing", views_due.size());
      $display("yaw_pitch_camera_orientation_move test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #30ms;
    $display("yaw_pitch_camera_orientation_move test failed");
    $finish;
  end

endmodule
